@@ hdl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing else.
package spq_pkg;

	localparam int PRIO_W     = 3;
	localparam int TAG_PORT_W = 16;
	localparam int OCC_W      = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic [PRIO_W-1:0] MAX_PRIORITY = 3'd5;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_POP    = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Command broadcast to every cell of the row in the same cycle.
	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

endpackage

@@ hdl/spq_cell.sv @@
// One slot of the sorted row: holds a priority and a tag, shifts with its neighbours.
// Depends on spq_pkg.
module spq_cell #(
	parameter int TAG_WIDTH = 16
) (
	input  logic                      clk,
	input  spq_pkg::cmd_t             cmd,
	input  logic                      occupied,
	input  logic                      left_displace,
	input  logic [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic [TAG_WIDTH-1:0]      left_tag,
	input  logic [spq_pkg::PRIO_W-1:0] right_prio,
	input  logic [TAG_WIDTH-1:0]      right_tag,
	input  logic [TAG_WIDTH-1:0]      new_tag,
	output logic                      displace,
	output logic [spq_pkg::PRIO_W-1:0] prio,
	output logic [TAG_WIDTH-1:0]      tag
);

	logic [spq_pkg::PRIO_W-1:0] prio_q;
	logic [TAG_WIDTH-1:0]       tag_q;

	// Give way to the new entry when empty or strictly lower in priority.
	assign displace = !occupied || (prio_q < cmd.prio);

	always_ff @(posedge clk) begin
		if (cmd.ins && displace) begin
			if (left_displace) begin
				prio_q <= left_prio;
				tag_q  <= left_tag;
			end else begin
				prio_q <= cmd.prio;
				tag_q  <= new_tag;
			end
		end else if (cmd.pop) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end
	end

	assign prio = prio_q;
	assign tag  = tag_q;

endmodule

@@ hdl/stable_priority_queue.sv @@
// Top level of the stable priority queue: a row of spq_cell slots, occupancy count
// and the output register. Depends on spq_pkg and spq_cell.
//
//  channel  | dir | tdata (low bit up)                       | tuser
//  ---------+-----+------------------------------------------+-------------------
//  s_axis   | in  | priority_req[2:0], tag[18:3], pad to 24   | req_type (0 ins, 1 pop)
//  m_axis   | out | out_tag[15:0], out_priority[18:16],       | status[1:0]
//           |     | occupancy[23:19]                         |
//
// One request per cycle while s_tready is high: the whole row of cells updates in
// the cycle of the transfer, each cell taking from its left neighbour, the new entry,
// its right neighbour, or holding. The result is registered and shown in the next cycle.
// s_tready is low only while a result waits and m_tready is low.
// arst_n clears the count and the output valid; slot contents need no reset.
module stable_priority_queue #(
	parameter int DEPTH     = 16,
	parameter int TAG_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,  // priority_req, tag, zero pad
	input  logic                            s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,  // out_tag, out_priority, occupancy
	output logic [1:0]                      m_tuser   // status
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TW_IN = (TAG_WIDTH < spq_pkg::TAG_PORT_W) ? TAG_WIDTH
		: spq_pkg::TAG_PORT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [CNT_W-1:0] count_q;
	logic             m_tvalid_q;
	logic [1:0]       status_q;
	logic [spq_pkg::TAG_PORT_W-1:0] out_tag_q;
	logic [spq_pkg::PRIO_W-1:0]     out_prio_q;
	logic [spq_pkg::OCC_W-1:0]      occ_q;

	logic                        xfer;
	logic                        is_pop;
	logic                        full;
	logic                        empty;
	logic [spq_pkg::PRIO_W-1:0]  req_prio;
	logic [spq_pkg::PRIO_W-1:0]  clamp_prio;
	logic [TAG_WIDTH-1:0]        new_tag;
	spq_pkg::cmd_t               cmd;
	logic [CNT_W-1:0]            count_d;
	logic [1:0]                  status_d;
	logic [spq_pkg::TAG_PORT_W-1:0] pop_tag;

	logic                       displace_w [DEPTH];
	logic [spq_pkg::PRIO_W-1:0] prio_w     [DEPTH];
	logic [TAG_WIDTH-1:0]       tag_w      [DEPTH];

	// Accept whenever the output register is free or being emptied.
	assign s_tready = !m_tvalid_q || m_tready;
	assign xfer     = s_tvalid && s_tready;
	assign is_pop   = (s_tuser == spq_pkg::REQ_POP);
	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);

	// Fold out-of-range priorities to zero.
	assign req_prio   = s_tdata[spq_pkg::PRIO_W-1:0];
	assign clamp_prio = (req_prio > spq_pkg::MAX_PRIORITY) ? '0 : req_prio;

	always_comb begin
		new_tag = '0;
		new_tag[TW_IN-1:0] = s_tdata[spq_pkg::PRIO_W +: TW_IN];
		pop_tag = '0;
		pop_tag[TW_IN-1:0] = tag_w[0][TW_IN-1:0];
	end

	// Drop the command when the request cannot change the row.
	always_comb begin
		cmd.ins  = xfer && !is_pop && !full;
		cmd.pop  = xfer && is_pop && !empty;
		cmd.prio = clamp_prio;
	end

	always_comb begin
		count_d  = count_q;
		status_d = spq_pkg::ST_INSERTED;
		if (is_pop) begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				status_d = spq_pkg::ST_POPPED;
				count_d  = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end
	end

	// Row of cells, front at index 0.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                       l_disp;
			logic [spq_pkg::PRIO_W-1:0] l_prio;
			logic [TAG_WIDTH-1:0]       l_tag;
			logic [spq_pkg::PRIO_W-1:0] r_prio;
			logic [TAG_WIDTH-1:0]       r_tag;

			if (gi == 0) begin : g_front
				assign l_disp = 1'b0;
				assign l_prio = '0;
				assign l_tag  = '0;
			end else begin : g_mid_l
				assign l_disp = displace_w[gi-1];
				assign l_prio = prio_w[gi-1];
				assign l_tag  = tag_w[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_back
				assign r_prio = '0;
				assign r_tag  = '0;
			end else begin : g_mid_r
				assign r_prio = prio_w[gi+1];
				assign r_tag  = tag_w[gi+1];
			end

			spq_cell #(
				.TAG_WIDTH(TAG_WIDTH)
			) u_cell (
				.clk          (clk),
				.cmd          (cmd),
				.occupied     (CNT_W'(gi) < count_q),
				.left_displace(l_disp),
				.left_prio    (l_prio),
				.left_tag     (l_tag),
				.right_prio   (r_prio),
				.right_tag    (r_tag),
				.new_tag      (new_tag),
				.displace     (displace_w[gi]),
				.prio         (prio_w[gi]),
				.tag          (tag_w[gi])
			);
		end
	endgenerate

	// Update the count on every transfer; it stays put for a pop on an empty row or an insert on a full one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q <= count_d;
			end
			if (xfer) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload until the next transfer.
	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q <= status_d;
			occ_q    <= spq_pkg::OCC_W'(count_d);
			if (is_pop && !empty) begin
				out_tag_q  <= pop_tag;
				out_prio_q <= prio_w[0];
			end else begin
				out_tag_q  <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {occ_q, out_prio_q, out_tag_q};

	// Count never runs past the row length.
	a_count_range : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("occupancy above depth");

	// A pop on a non-empty row frees exactly one slot.
	a_pop_dec : assert property (@(posedge clk) disable iff (!arst_n)
		xfer && is_pop && !empty |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not free one slot");

	// The two front cells stay in priority order.
	a_front_sorted : assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> prio_w[0] >= prio_w[1])
		else $error("front of row out of order");

	// A popped entry never carries an out-of-range priority.
	a_pop_prio : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && status_q == spq_pkg::ST_POPPED |-> out_prio_q <= spq_pkg::MAX_PRIORITY)
		else $error("popped priority out of range");

endmodule
